@@ hdl/pmsu_pkg.sv @@
package pmsu_pkg;

   localparam int NUM_STACKS        = 8;
   localparam int ENTRIES_PER_STACK = 16;
   localparam int STORE_DEPTH       = NUM_STACKS * ENTRIES_PER_STACK;

   localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(ENTRIES_PER_STACK + 1);

   localparam int WORD_W = 32;

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // one access of the shared word store
   typedef struct packed {
      logic     write;
      addr_type addr;
      word_type wdata;
   } store_req_type;

   // result bookkeeping held beside the store read
   typedef struct packed {
      logic       valid;
      logic       use_store;
      logic       peek_empty;
      status_type status;
      logic       full;
      logic       empty;
   } rsp_meta_type;

endpackage

@@ hdl/pmsu_store.sv @@
module pmsu_store
   import pmsu_pkg::*;
(
   input  logic          clock,
   input  store_req_type store_req,
   output word_type      rdata
);

   word_type word_store [STORE_DEPTH];
   word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (store_req.write) begin
         word_store[store_req.addr] <= store_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= word_store[store_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/pmsu_control.sv @@
module pmsu_control
   import pmsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [1:0]     operation,
   input  logic [2:0]     stack_index,
   input  word_type       push_value,
   output store_req_type  store_req,
   output rsp_meta_type   rsp_meta
);

   count_type    fill_count_ff [NUM_STACKS];
   count_type    count_in;
   logic         count_write;
   rsp_meta_type rsp_meta_ff;
   rsp_meta_type rsp_meta_in;

   logic [STACK_W-1:0] sel;
   logic               in_range;
   count_type          cnt;
   logic               cnt_zero;
   logic               cnt_full;
   addr_type           base;
   op_type             op;

   assign sel      = STACK_W'(stack_index);
   assign in_range = 32'(stack_index) < NUM_STACKS;
   assign cnt      = in_range ? fill_count_ff[sel] : '0;
   assign cnt_zero = (cnt == '0);
   assign cnt_full = (cnt == CNT_W'(ENTRIES_PER_STACK));
   assign base     = ADDR_W'(32'(sel) * ENTRIES_PER_STACK);
   assign op       = op_type'(operation);

   always_comb begin
      count_in            = cnt;
      count_write         = 1'b0;
      store_req.write     = 1'b0;
      store_req.addr      = base + ADDR_W'(cnt - CNT_W'(1));
      store_req.wdata     = push_value;
      rsp_meta_in.valid      = accept;
      rsp_meta_in.use_store  = 1'b0;
      rsp_meta_in.peek_empty = 1'b0;
      rsp_meta_in.status     = STATUS_DONE;
      unique case (op)
         OP_PUSH: begin
            store_req.addr = base + ADDR_W'(cnt);
            if (cnt_full) begin
               rsp_meta_in.status = STATUS_FULL;
            end else begin
               count_in        = cnt + CNT_W'(1);
               count_write     = in_range;
               store_req.write = accept && in_range;
            end
         end
         OP_POP: begin
            if (cnt_zero) begin
               rsp_meta_in.status = STATUS_EMPTY;
            end else begin
               count_in              = cnt - CNT_W'(1);
               count_write           = in_range;
               rsp_meta_in.use_store = 1'b1;
            end
         end
         OP_PEEK: begin
            if (cnt_zero) begin
               rsp_meta_in.status     = STATUS_EMPTY;
               rsp_meta_in.peek_empty = 1'b1;
            end else begin
               rsp_meta_in.use_store = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!in_range) begin
         rsp_meta_in.status     = STATUS_DONE;
         rsp_meta_in.use_store  = 1'b0;
         rsp_meta_in.peek_empty = 1'b0;
      end
      rsp_meta_in.full  = in_range && (count_in == CNT_W'(ENTRIES_PER_STACK));
      rsp_meta_in.empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            fill_count_ff[i] <= '0;
         end
      end else if (accept && count_write) begin
         fill_count_ff[sel] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_meta_ff.valid <= 1'b0;
      end else begin
         rsp_meta_ff.valid <= rsp_meta_in.valid;
      end
      rsp_meta_ff.use_store  <= rsp_meta_in.use_store;
      rsp_meta_ff.peek_empty <= rsp_meta_in.peek_empty;
      rsp_meta_ff.status     <= rsp_meta_in.status;
      rsp_meta_ff.full       <= rsp_meta_in.full;
      rsp_meta_ff.empty      <= rsp_meta_in.empty;
   end

   assign rsp_meta = rsp_meta_ff;

endmodule

@@ hdl/partitioned_multi_stack_unit.sv @@
// eight lifo stacks of sixteen signed words share one 128-word store, cut into
// fixed partitions; each item pushes, pops or peeks one stack. an item is taken
// whenever start is high: busy is never raised, so a new item may enter every
// cycle. the result appears on the rsp_ ports in the cycle after the item is
// taken, for one cycle only, marked by rsp_valid; the receiver cannot stall
// it and must take it then. the result is registered, as the word store has a
// registered read port; the per-stack fill counts are updated in the accept
// cycle, so back-to-back items on the same stack see each other's effects.
// a push onto a full stack reports status full and changes nothing; a pop or
// peek of an empty stack reports status empty and returns 0 (pop) or -1 (peek).
module partitioned_multi_stack_unit
   import pmsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_stack_index,
   input  logic signed [31:0] req_push_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_now_full,
   output logic        rsp_now_empty
);

   store_req_type store_req;
   rsp_meta_type  rsp_meta;
   word_type      store_rdata;
   logic          accept;

   // never stalls: an item is taken in any cycle, its result follows in the next cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // fill counts, op decode and store addressing
   pmsu_control u_control (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .stack_index (req_stack_index),
      .push_value  (req_push_value),
      .store_req   (store_req),
      .rsp_meta    (rsp_meta)
   );

   // shared word store, registered read
   pmsu_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rdata     (store_rdata)
   );

   // popped or peeked word, otherwise the fixed answer for the case
   always_comb begin
      if (rsp_meta.use_store) begin
         rsp_read_value = store_rdata;
      end else if (rsp_meta.peek_empty) begin
         rsp_read_value = '1;
      end else begin
         rsp_read_value = '0;
      end
   end

   assign rsp_valid     = rsp_meta.valid;
   assign rsp_status    = rsp_meta.status;
   assign rsp_now_full  = rsp_meta.full;
   assign rsp_now_empty = rsp_meta.empty;

   // one result for each item taken, in the cycle after
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid == $past(accept)))
      else $error("result strobe does not follow item acceptance");

   // a refused push leaves the stack full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> rsp_now_full)
      else $error("push refused while stack not full");

   // a refused pop or peek leaves the stack empty, and never uses the store
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_now_empty && !rsp_meta.use_store))
      else $error("empty refusal with inconsistent flags");

   // a stack is never full and empty at once
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_now_full && rsp_now_empty))
      else $error("stack reported full and empty");

endmodule

@@ verif/tb_partitioned_multi_stack_unit.sv @@
module tb_partitioned_multi_stack_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pmsu_pkg::*;

   // one result item as the stack unit should report it
   typedef struct packed {
      word_type   read_value;
      status_type status;
      logic       now_full;
      logic       now_empty;
   } stack_reply_type;

   // bound on the whole run: far above the slowest legal run of ~1050 items
   localparam int CYCLE_LIMIT = 400_000;
   // the unused operation code, never a member of op_type
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LAST_STACK = NUM_STACKS - 1;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_operation;
   logic [2:0]        req_stack_index;
   logic signed [31:0] req_push_value;
   logic              rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic [1:0]        rsp_status;
   logic              rsp_now_full;
   logic              rsp_now_empty;

   // predictor state: its own copy of the partitioned store and fill counts
   word_type        shadow_words [STORE_DEPTH];
   int unsigned     shadow_fill  [NUM_STACKS];
   // replies still owed by the block, oldest first
   stack_reply_type awaited_replies [$];

   int  error_count = 0;
   int  cycle_count = 0;
   // when set, items go in back to back with no idle cycles between them
   bit  burst_mode  = 1'b0;

   partitioned_multi_stack_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_stack_index (req_stack_index),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_now_full    (rsp_now_full),
      .rsp_now_empty   (rsp_now_empty)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a stuck handshake ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_partitioned_multi_stack_unit: done, errors");
      $finish;
   end

   // predictor: applies one operation to the shadow state, gives the reply
   function automatic stack_reply_type apply_stack_op(logic [1:0] op, logic [2:0] idx,
                                                      word_type value);
      stack_reply_type reply;
      int unsigned     base;
      int unsigned     fill;
      reply.read_value = '0;
      reply.status     = STATUS_DONE;
      reply.now_full   = 1'b0;
      reply.now_empty  = 1'b1;
      if (int'(idx) < NUM_STACKS) begin
         base = int'(idx) * ENTRIES_PER_STACK;
         fill = shadow_fill[idx];
         case (op)
            OP_PUSH: begin
               if (fill >= ENTRIES_PER_STACK) begin
                  reply.status = STATUS_FULL;
               end else begin
                  shadow_words[base + fill] = value;
                  fill++;
               end
            end
            OP_POP: begin
               if (fill == 0) begin
                  reply.status = STATUS_EMPTY;
               end else begin
                  fill--;
                  reply.read_value = shadow_words[base + fill];
               end
            end
            OP_PEEK: begin
               if (fill == 0) begin
                  reply.status     = STATUS_EMPTY;
                  reply.read_value = '1;
               end else begin
                  reply.read_value = shadow_words[base + fill - 1];
               end
            end
            default: begin
               // unused code: state untouched, flags of the addressed stack only
            end
         endcase
         shadow_fill[idx] = fill;
         reply.now_full   = (fill == ENTRIES_PER_STACK);
         reply.now_empty  = (fill == 0);
      end
      return reply;
   endfunction

   // idle lengths: mostly none or short, now and then a long pause
   function automatic int unsigned random_gap();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 50)      return 0;
      else if (roll < 85) return $urandom_range(3, 1);
      else if (roll < 97) return $urandom_range(12, 4);
      else                return $urandom_range(60, 20);
   endfunction

   // push data: mostly any word, sometimes an extreme of the signed range, zero or -1
   function automatic word_type random_word();
      int unsigned roll;
      roll = $urandom_range(19, 0);
      case (roll)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // idle: start held low; the request fields carry noise meanwhile
   task automatic idle_for(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start           <= 1'b0;
         req_operation   <= 2'($urandom_range(3, 0));
         req_stack_index <= 3'($urandom_range(7, 0));
         req_push_value  <= $urandom();
      end
   endtask

   // one item: drive on the falling edge, wait for the taking edge, predict
   task automatic send_item(logic [1:0] op, logic [2:0] idx, word_type value);
      @(negedge clock);
      start           <= 1'b1;
      req_operation   <= op;
      req_stack_index <= idx;
      req_push_value  <= value;
      do @(posedge clock); while (busy !== 1'b0);
      awaited_replies.push_back(apply_stack_op(op, idx, value));
      if (!burst_mode) idle_for(random_gap());
   endtask

   // reply checker: every strobe must match the oldest owed reply
   always @(posedge clock) begin
      stack_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            $error("reply with nothing owed: read_value %0d status %0d",
                   rsp_read_value, rsp_status);
            error_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d",
                      $signed(want.read_value), rsp_read_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_now_full !== want.now_full) begin
               $error("now_full: expected %0b, actual %0b", want.now_full, rsp_now_full);
               error_count++;
            end
            if (rsp_now_empty !== want.now_empty) begin
               $error("now_empty: expected %0b, actual %0b", want.now_empty, rsp_now_empty);
               error_count++;
            end
         end
      end
   end

   // every stack starts empty: refused pops and peeks, unused code on empty
   task automatic test_empty_stacks();
      send_item(OP_POP,    3'd0, 32'h1234_5678);
      send_item(OP_PEEK,   LAST_STACK[2:0], 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 3'd3, 32'h0);
      send_item(OP_PEEK,   3'd0, 32'h8000_0000);
   endtask

   // extremes of the signed word through push, peek and pop
   task automatic test_word_extremes();
      send_item(OP_PUSH,   3'd0, 32'h7FFF_FFFF);
      send_item(OP_PUSH,   LAST_STACK[2:0], 32'h8000_0000);
      send_item(OP_PUSH,   3'd3, 32'h0000_0000);
      send_item(OP_PUSH,   3'd3, 32'hFFFF_FFFF);
      // a pushed -1 must read back as data, not as an empty peek
      send_item(OP_PEEK,   3'd3, 32'h5555_5555);
      send_item(OP_POP,    3'd3, 32'hAAAA_AAAA);
      send_item(OP_POP,    3'd3, 32'h0);
      send_item(OP_POP,    LAST_STACK[2:0], 32'h0);
      // unused code on a stack that holds a word
      send_item(OP_UNUSED, 3'd0, 32'hFFFF_FFFF);
   endtask

   // fill one stack to the top, then a refused push, then back off by one
   task automatic test_full_stack();
      logic [2:0] victim;
      victim = 3'($urandom_range(7, 0));
      while (shadow_fill[victim] < ENTRIES_PER_STACK)
         send_item(OP_PUSH, victim, random_word());
      send_item(OP_PUSH,   victim, 32'hDEAD_BEEF);
      send_item(OP_UNUSED, victim, 32'h0);
      send_item(OP_PEEK,   victim, 32'h0);
      send_item(OP_POP,    victim, 32'h0);
   endtask

   // random phases: each leans towards pushes or pops, and some hammer one
   // stack so that full and empty stacks come round often
   task automatic test_random_phases();
      int unsigned push_weight;
      int unsigned roll;
      bit          focused;
      logic [2:0]  focus_stack;
      logic [2:0]  idx;
      logic [1:0]  op;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(2, 0))
            0:       push_weight = 75;
            1:       push_weight = 45;
            default: push_weight = 20;
         endcase
         focused     = ($urandom_range(9, 0) < 6);
         focus_stack = 3'($urandom_range(7, 0));
         // a quarter of the phases run with no idle cycles at all
         burst_mode  = ($urandom_range(3, 0) == 0);
         for (int n = 0; n < 100; n++) begin
            idx = (focused && $urandom_range(9, 0) < 8) ? focus_stack
                                                        : 3'($urandom_range(7, 0));
            roll = $urandom_range(99, 0);
            if (roll < 5)                      op = OP_UNUSED;
            else if (roll < 5 + push_weight)   op = OP_PUSH;
            else if ($urandom_range(2, 0) < 2) op = OP_POP;
            else                               op = OP_PEEK;
            send_item(op, idx, random_word());
         end
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      int unsigned settle;
      for (int s = 0; s < NUM_STACKS; s++) shadow_fill[s] = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_PUSH;
      req_stack_index = '0;
      req_push_value  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_stacks();
      test_word_extremes();
      test_full_stack();
      test_random_phases();

      // stimulus over: lower start and let the last replies come home
      idle_for(1);
      settle = 0;
      while (awaited_replies.size() != 0 && settle < 50) begin
         @(posedge clock);
         settle++;
      end
      if (awaited_replies.size() != 0) begin
         $error("replies never seen: %0d still owed", awaited_replies.size());
         error_count++;
      end
      // wait on to catch any stray strobe
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("tb_partitioned_multi_stack_unit: done, clean");
      else
         $display("tb_partitioned_multi_stack_unit: done, errors");
      $finish;
   end

endmodule
